[hw/rtl/array_list_engine_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the array list engine
// Shared concurrent assertion forms used by array_list_engine_core.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// implication checked every cycle outside reset
`define ALE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ALE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/ale_pkg.sv]
// ----------------------------------------------------------------------------
// ale_pkg
// Types and constants of the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;
    localparam int unsigned CAPACITY_DEF = 256;

    localparam logic [3:0] OP_APPEND   = 4'd0;
    localparam logic [3:0] OP_INS_POS  = 4'd1;
    localparam logic [3:0] OP_DEL_POS  = 4'd2;
    localparam logic [3:0] OP_SEARCH   = 4'd3;
    localparam logic [3:0] OP_DEL_KEY  = 4'd4;
    localparam logic [3:0] OP_INS_KEY  = 4'd5;
    localparam logic [3:0] OP_READ     = 4'd6;
    localparam logic [3:0] OP_REVERSE  = 4'd7;
    localparam logic [3:0] OP_SORT     = 4'd8;
    localparam logic [3:0] OP_SORT_INS = 4'd9;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_NOKEY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [3:0]         operation;
        logic [7:0]         position;
        logic signed [31:0] search_key;
        logic signed [31:0] new_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         found_index;
        logic signed [31:0] read_value;
        logic [8:0]         element_total;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_UP,
        S_DOWN,
        S_REV,
        S_SORT,
        S_SINS,
        S_PUT,
        S_RDWAIT,
        S_DONE
    } t_state;
endpackage

[hw/rtl/ale_ram.sv]
// ----------------------------------------------------------------------------
// ale_ram
// Single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/array_list_engine_core.sv]
// Append, unused codes, bad-position answers and full answers (but for key insert)
//   finish in the dispatch state; read goes through S_RDWAIT; positional, key and
//   reverse operations walk the n stored elements; sort runs bubble passes, and
//   sorted insert then walks down. One word is in flight; o_ready rises in the cycle
//   after the result word leaves. The RAM serves one read and one write per cycle.
// Reset: synchronous, clears the count and the control; element memory is not cleared.
// ----------------------------------------------------------------------------
// array_list_engine_core
// Packed list of signed words held in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
`include "array_list_engine_core_defines.svh"
module array_list_engine_core #(
    parameter int unsigned CAPACITY = ale_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ale_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ale_pkg::t_out_word o_data
);
    import ale_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;
    t_in_word r_req;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_pass, n_pass;
    logic          r_ph, n_ph;
    logic [31:0]   r_hold, n_hold;
    logic          r_vld;
    t_out_word     r_out, n_out;
    logic          fin;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    ale_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic full;
    logic [CW-1:0] pos_w;
    logic pos_bad;
    assign full    = (r_cnt >= CW'(CAPACITY));
    assign pos_w   = CW'(r_req.position);
    assign pos_bad = (32'(r_req.position) >= 32'(r_cnt));

    function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
        sgt = $signed(a) > $signed(b);
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_DISPATCH;
            S_DONE:     if (!r_vld || i_ready) n_state = S_IDLE;
            default:    if (fin) n_state = S_DONE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_pass = r_pass; n_ph = r_ph;
        n_hold = r_hold; n_out = r_out; fin = 1'b0;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        case (r_state)
            S_DISPATCH: begin
                n_out = '0; n_i = '0; n_ph = 1'b0; n_pass = '0;
                case (r_req.operation)
                    OP_APPEND: begin
                        if (full) n_out.status = ST_FULL;
                        else begin
                            we = 1'b1; waddr = AW'(r_cnt); wdata = r_req.new_value;
                            n_cnt = r_cnt + 1'b1;
                        end
                        fin = 1'b1;
                    end
                    OP_INS_POS, OP_DEL_POS, OP_READ: begin
                        if (pos_bad) begin
                            n_out.status = ST_BADPOS; fin = 1'b1;
                        end else if (r_req.operation == OP_INS_POS && full) begin
                            n_out.status = ST_FULL; fin = 1'b1;
                        end else begin
                            n_j = pos_w;
                            n_i = (r_req.operation == OP_DEL_POS) ? pos_w + 1'b1 : r_cnt;
                            fin = 1'b0;
                        end
                    end
                    OP_SEARCH, OP_DEL_KEY, OP_INS_KEY: n_i = '0;
                    OP_REVERSE: begin n_i = '0; n_j = r_cnt; end
                    OP_SORT: begin n_pass = '0; n_j = '0; end
                    OP_SORT_INS: begin
                        if (full) begin n_out.status = ST_FULL; fin = 1'b1; end
                        n_pass = '0; n_j = '0;
                    end
                    default: fin = 1'b1;
                endcase
            end
            S_RDWAIT: begin
                if (!r_ph) begin raddr = AW'(r_j); n_ph = 1'b1; end
                else begin n_out.read_value = rdata; fin = 1'b1; end
            end
            S_SEARCH: begin
                // phase 0 issues read of r_i, phase 1 compares
                if (!r_ph) begin
                    if (r_i >= r_cnt) begin n_out.status = ST_NOKEY; fin = 1'b1; end
                    else begin raddr = AW'(r_i); n_ph = 1'b1; end
                end else begin
                    n_ph = 1'b0;
                    if (rdata == r_req.search_key) begin
                        n_j = r_i;
                        if (r_req.operation == OP_INS_KEY && full) begin
                            n_out.status = ST_FULL; fin = 1'b1;
                        end else begin
                            n_out.found_index = 8'(r_i);
                            if (r_req.operation == OP_SEARCH) fin = 1'b1;
                            else if (r_req.operation == OP_DEL_KEY) n_i = r_i + 1'b1;
                            else n_i = r_cnt;
                        end
                    end else n_i = r_i + 1'b1;
                end
            end
            S_UP: begin
                // move i-1 to i while i > j, then write value at j
                if (!r_ph) begin
                    if (r_i > r_j) begin raddr = AW'(r_i - 1'b1); n_ph = 1'b1; end
                    else begin
                        we = 1'b1; waddr = AW'(r_j); wdata = r_req.new_value;
                        n_cnt = r_cnt + 1'b1; fin = 1'b1;
                    end
                end else begin
                    we = 1'b1; waddr = AW'(r_i); wdata = rdata;
                    n_i = r_i - 1'b1; n_ph = 1'b0;
                end
            end
            S_DOWN: begin
                if (!r_ph) begin
                    if (r_i < r_cnt) begin raddr = AW'(r_i); n_ph = 1'b1; end
                    else begin n_cnt = r_cnt - 1'b1; fin = 1'b1; end
                end else begin
                    we = 1'b1; waddr = AW'(r_i - 1'b1); wdata = rdata;
                    n_i = r_i + 1'b1; n_ph = 1'b0;
                end
            end
            S_REV: begin
                // i = lo, j = hi (exclusive); phases: read lo, read hi, write lo, write hi
                case ({r_ph, r_pass[0]})
                    2'b00: begin
                        if (r_j > r_i + 1'b1) begin
                            raddr = AW'(r_i); n_ph = 1'b1;
                        end else fin = 1'b1;
                    end
                    2'b10: begin
                        raddr = AW'(r_j - 1'b1); n_hold = rdata;
                        n_pass = r_pass + 1'b1;
                    end
                    2'b11: begin
                        we = 1'b1; waddr = AW'(r_i); wdata = rdata;
                        n_ph = 1'b0;
                    end
                    default: begin
                        we = 1'b1; waddr = AW'(r_j - 1'b1); wdata = r_hold;
                        n_pass = r_pass + 1'b1;
                        n_i = r_i + 1'b1; n_j = r_j - 1'b1;
                    end
                endcase
                if ({r_ph, r_pass[0]} == 2'b01) n_ph = 1'b0;
            end
            S_SORT: begin
                // pass counts r_pass < cnt, inner j; ph0 read j, ph1 read j+1 hold j,
                // then compare, and on a swap write j from the read value and j+1 from hold
                case ({r_ph, r_i[0]})
                    2'b00: begin
                        if (r_pass >= r_cnt) begin
                            if (r_req.operation == OP_SORT) fin = 1'b1;
                            else begin n_i = '0; n_j = r_cnt; n_ph = 1'b0; end
                        end else if (r_j + 1'b1 >= r_cnt) begin
                            n_pass = r_pass + 1'b1; n_j = '0;
                        end else begin raddr = AW'(r_j); n_ph = 1'b1; end
                    end
                    2'b10: begin
                        raddr = AW'(r_j + 1'b1); n_hold = rdata; n_i[0] = 1'b1;
                    end
                    2'b11: begin
                        if (sgt(r_hold, rdata)) begin
                            we = 1'b1; waddr = AW'(r_j); wdata = rdata;
                            n_i[0] = 1'b0; n_ph = 1'b0;
                            n_hold = r_hold;
                            n_pass = r_pass; n_i = '0; n_i[0] = 1'b1; n_ph = 1'b0;
                        end else begin
                            n_i = '0; n_ph = 1'b0; n_j = r_j + 1'b1;
                        end
                    end
                    default: begin
                        we = 1'b1; waddr = AW'(r_j + 1'b1); wdata = r_hold;
                        n_i = '0; n_j = r_j + 1'b1;
                    end
                endcase
            end
            S_SINS: begin
                // j walks down from cnt; ph0 read j-1, ph1 compare
                if (!r_ph) begin
                    if (r_j > '0) begin raddr = AW'(r_j - 1'b1); n_ph = 1'b1; end
                    else begin
                        we = 1'b1; waddr = '0; wdata = r_req.new_value;
                        n_out.found_index = '0; n_cnt = r_cnt + 1'b1; fin = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    if (sgt(rdata, r_req.new_value)) begin
                        we = 1'b1; waddr = AW'(r_j); wdata = rdata;
                        n_j = r_j - 1'b1;
                    end else begin
                        we = 1'b1; waddr = AW'(r_j); wdata = r_req.new_value;
                        n_out.found_index = 8'(r_j);
                        n_cnt = r_cnt + 1'b1; fin = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (fin) n_out.element_total = 9'(n_cnt);
    end

    t_state sub_state;
    always_comb begin
        sub_state = r_state;
        if (r_state == S_DISPATCH && !fin) begin
            case (r_req.operation)
                OP_INS_POS:  sub_state = S_UP;
                OP_DEL_POS:  sub_state = S_DOWN;
                OP_READ:     sub_state = S_RDWAIT;
                OP_REVERSE:  sub_state = S_REV;
                OP_SORT, OP_SORT_INS: sub_state = S_SORT;
                default:     sub_state = S_SEARCH;
            endcase
        end else if (r_state == S_SEARCH && !fin && r_ph && rdata == r_req.search_key)
            sub_state = (r_req.operation == OP_DEL_KEY) ? S_DOWN : S_UP;
        else if (r_state == S_SORT && !fin && r_pass >= r_cnt && !r_ph && !r_i[0])
            sub_state = S_SINS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vld   <= 1'b0;
            r_ph    <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ph  <= n_ph;
            if (fin) r_state <= S_DONE;
            else if (sub_state != r_state) r_state <= sub_state;
            else r_state <= n_state;
            if (fin) r_vld <= 1'b1;
            else if (i_ready) r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_pass <= n_pass; r_hold <= n_hold; r_out <= n_out;
        if (r_state == S_IDLE && i_valid) r_req <= i_data;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_vld;
    assign o_data  = r_out;

    `ALE_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(CAPACITY))
    `ALE_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, fin, o_valid)
    `ALE_ASSERT_IMP(a_busy_nrdy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
endmodule

[tb/tb_array_list_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_array_list_engine_core
// Self-checking bench for the array list engine: words go in through a
// bursty sender, a local list model predicts each result, and a stalling
// receiver compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_array_list_engine_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ale_pkg::*;

    localparam int CAP         = 256;
    localparam int SMALL_MAX   = 16;
    localparam int CYCLE_LIMIT = 10000000;

    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    array_list_engine_core #(.CAPACITY(CAP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #2 i_clk = ~i_clk;

    logic signed [31:0] list_mem [CAP];
    int                 list_len;
    t_out_word          expected_q[$];
    int                 err_count;
    int                 rx_hold;
    int                 burst_left;
    int                 cycle_count;

    function automatic int find_first(logic signed [31:0] key);
        for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == key) return i;
        end
        return CAP;
    endfunction

    function automatic void place_at(int pos, logic signed [31:0] v);
        for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
        list_mem[pos] = v;
        list_len++;
    endfunction

    function automatic void remove_at(int pos);
        for (int i = pos + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
        list_len--;
    endfunction

    function automatic void bubble_sort();
        logic signed [31:0] t;
        for (int i = 0; i < list_len; i++) begin
            for (int j = 0; j + 1 < list_len; j++) begin
                if (list_mem[j] > list_mem[j+1]) begin
                    t = list_mem[j];
                    list_mem[j] = list_mem[j+1];
                    list_mem[j+1] = t;
                end
            end
        end
    endfunction

    function automatic t_out_word predict_list_op(t_in_word w);
        t_out_word r;
        logic full;
        int f, lo, hi, i;
        logic signed [31:0] t;
        r = '0;
        full = (list_len >= CAP);
        case (w.operation)
            OP_APPEND: begin
                if (full) r.status = ST_FULL;
                else begin
                    list_mem[list_len] = w.new_value;
                    list_len++;
                end
            end
            OP_INS_POS: begin
                if (w.position >= list_len) r.status = ST_BADPOS;
                else if (full) r.status = ST_FULL;
                else place_at(w.position, w.new_value);
            end
            OP_DEL_POS: begin
                if (w.position >= list_len) r.status = ST_BADPOS;
                else remove_at(w.position);
            end
            OP_SEARCH, OP_DEL_KEY, OP_INS_KEY: begin
                f = find_first(w.search_key);
                if (f >= list_len) r.status = ST_NOKEY;
                else if (w.operation == OP_INS_KEY && full) r.status = ST_FULL;
                else begin
                    r.found_index = f[7:0];
                    if (w.operation == OP_DEL_KEY) remove_at(f);
                    else if (w.operation == OP_INS_KEY) place_at(f, w.new_value);
                end
            end
            OP_READ: begin
                if (w.position >= list_len) r.status = ST_BADPOS;
                else r.read_value = list_mem[w.position];
            end
            OP_REVERSE: begin
                lo = 0;
                hi = list_len;
                while (hi > lo + 1) begin
                    hi--;
                    t = list_mem[lo];
                    list_mem[lo] = list_mem[hi];
                    list_mem[hi] = t;
                    lo++;
                end
            end
            OP_SORT: bubble_sort();
            OP_SORT_INS: begin
                if (full) r.status = ST_FULL;
                else begin
                    bubble_sort();
                    i = list_len;
                    while (i > 0 && list_mem[i-1] > w.new_value) begin
                        list_mem[i] = list_mem[i-1];
                        i--;
                    end
                    list_mem[i] = w.new_value;
                    list_len++;
                    r.found_index = i[7:0];
                end
            end
            default: ;
        endcase
        r.element_total = list_len[8:0];
        return r;
    endfunction

    task automatic send_word(t_in_word w);
        i_data  <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(predict_list_op(w));
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic issue(logic [3:0] op, logic [7:0] pos,
                         logic signed [31:0] key, logic signed [31:0] val);
        t_in_word w;
        w.operation  = op;
        w.position   = pos;
        w.search_key = key;
        w.new_value  = val;
        send_word(w);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 8)) - 4;
    endfunction

    task automatic random_op();
        logic [3:0] op;
        logic [7:0] pos;
        logic signed [31:0] key;
        op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
                                          : 4'($urandom_range(0, 9));
        if (list_len >= SMALL_MAX && (op == OP_APPEND || op == OP_INS_POS ||
                                      op == OP_INS_KEY || op == OP_SORT_INS))
            op = ($urandom_range(0, 1) == 0) ? OP_DEL_POS : OP_DEL_KEY;
        if ($urandom_range(0, 9) == 0) pos = 8'($urandom);
        else pos = 8'($urandom_range(0, list_len));
        if (list_len > 0 && $urandom_range(0, 9) < 6)
            key = list_mem[$urandom_range(0, list_len - 1)];
        else key = pick_value();
        issue(op, pos, key, pick_value());
    endtask

    task automatic test_basic_ops();
        issue(OP_READ, 8'd0, 0, 0);
        issue(OP_DEL_POS, 8'd0, 0, 0);
        issue(OP_INS_POS, 8'd0, 0, 5);
        issue(OP_SEARCH, 8'd0, 0, 0);
        issue(OP_DEL_KEY, 8'd0, 0, 0);
        issue(OP_INS_KEY, 8'd0, 0, 7);
        issue(OP_REVERSE, 8'd0, 0, 0);
        issue(OP_SORT, 8'd0, 0, 0);
        issue(OP_SORT_INS, 8'd0, 0, 32'sh7fffffff);
        issue(OP_UNUSED_HI, 8'hff, -1, -1);
        issue(OP_UNUSED_LO, 8'd0, 0, 0);
        issue(OP_APPEND, 8'd0, 0, 32'sh80000000);
        issue(OP_APPEND, 8'd0, 0, 0);
        issue(OP_APPEND, 8'd0, 0, -1);
        issue(OP_INS_POS, 8'd0, 0, 3);
        issue(OP_INS_POS, 8'd4, 0, 9);
        issue(OP_READ, 8'd4, 0, 0);
        issue(OP_READ, 8'hff, 0, 0);
        issue(OP_SEARCH, 8'd0, -1, 0);
        issue(OP_INS_KEY, 8'd0, 0, 0);
        issue(OP_DEL_KEY, 8'd0, 32'sh7fffffff, 0);
        issue(OP_REVERSE, 8'd0, 0, 0);
        issue(OP_SORT, 8'd0, 0, 0);
        issue(OP_SORT_INS, 8'd0, 0, 0);
        issue(OP_SORT_INS, 8'd0, 0, 32'sh80000000);
        issue(OP_DEL_POS, 8'd2, 0, 0);
    endtask

    task automatic test_full_list();
        while (list_len < CAP) issue(OP_APPEND, 8'd0, 0, $urandom);
        issue(OP_APPEND, 8'd0, 0, 1);
        issue(OP_INS_POS, 8'd0, 0, 1);
        issue(OP_INS_POS, 8'hff, 0, 1);
        issue(OP_INS_KEY, 8'd0, list_mem[0], 1);
        issue(OP_INS_KEY, 8'd0, list_mem[CAP-1] ^ 32'sh1, 1);
        issue(OP_SORT_INS, 8'd0, 0, 1);
        issue(OP_SEARCH, 8'd0, list_mem[CAP-1], 0);
        issue(OP_READ, 8'hff, 0, 0);
        issue(OP_REVERSE, 8'd0, 0, 0);
        issue(OP_READ, 8'hff, 0, 0);
        issue(OP_DEL_POS, 8'hff, 0, 0);
        while (list_len > 0) issue(OP_DEL_POS, 8'd0, 0, 0);
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        repeat (60) random_op();
    endtask

    task automatic test_random_ops();
        repeat (900) random_op();
    endtask

    // receiver: long hold when requested, otherwise a shifting stall rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            case ((cycle_count / 97) % 3)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word %h", o_data);
                err_count++;
            end else begin
                e = expected_q.pop_front();
                if (o_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_data.status);
                    err_count++;
                end
                if (o_data.found_index !== e.found_index) begin
                    $error("found_index exp %0d got %0d", e.found_index,
                           o_data.found_index);
                    err_count++;
                end
                if (o_data.read_value !== e.read_value) begin
                    $error("read_value exp %0d got %0d", e.read_value,
                           o_data.read_value);
                    err_count++;
                end
                if (o_data.element_total !== e.element_total) begin
                    $error("element_total exp %0d got %0d", e.element_total,
                           o_data.element_total);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        list_len    = 0;
        err_count   = 0;
        rx_hold     = 0;
        burst_left  = 0;
        cycle_count = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_full_list();
        test_backpressure();
        test_random_ops();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ale_pkg.sv
hw/rtl/ale_ram.sv
hw/rtl/array_list_engine_core.sv
tb/tb_array_list_engine_core.sv
